@@ src/assert_macros.svh @@
// assertion macros used by the checker file
// ASSERT_CLKD expects clk and rst_n, ASSERT_CLK expects clk, to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// clocked check, active through reset as well
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/crcgc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the crc generate and check block
// no dependencies
package crcgc_pkg;

    localparam int POLY_W    = 32;
    localparam int DEGCFG_W  = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_DEG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE = 2'd2;

    // reset values of the configuration registers
    localparam logic [POLY_W-1:0]   POLY_LOW_RST = 32'h0000_0007;
    localparam logic [DEGCFG_W-1:0] POLY_DEG_RST = 6'd8;

    // command opcodes between front and back
    localparam logic OP_ECHO    = 1'b0;
    localparam logic OP_VERDICT = 1'b1;

    typedef struct packed {
        logic op;
        logic data_bit;
        logic err;
        logic tail;
    } crcgc_cmd_t;

endpackage

@@ src/crc_generate_and_check.sv @@
`timescale 1ns / 1ps
// an input transfer passes the command queue register, then the back part's output register
// throughput: one input bit per cycle while the queue is not full; a generate-mode message end gives degree+1
//   results at one per cycle while results are popped, the back part's tail shifter sets that pace
// a two-entry command queue takes two more bits while a crc tail drains, then
//   input stalls until the tail is out
// reset: poly low bits 0x7, degree 8, generate mode, remainder zero, queue empty
module crc_generate_and_check
    import crcgc_pkg::*;
#(
    parameter int MAX_DEGREE = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POLY_W-1:0]    cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 data_bit,
    input  logic                 end_of_message,
    output logic                 empty,
    input  logic                 pop,
    output logic                 result_kind,
    output logic                 code_bit,
    output logic                 error_found,
    output logic                 last_result
);

    localparam int DEG_W = $clog2(MAX_DEGREE + 1);
    localparam int CMD_W = $bits(crcgc_cmd_t);
    localparam int Q_W   = CMD_W + MAX_DEGREE + DEG_W;

    logic                  q_wr;
    logic                  q_rd;
    logic                  q_full;
    logic                  q_empty;
    crcgc_cmd_t            wr_cmd;
    logic [MAX_DEGREE-1:0] wr_rem;
    logic [DEG_W-1:0]      wr_deg;
    crcgc_cmd_t            rd_cmd;
    logic [MAX_DEGREE-1:0] rd_rem;
    logic [DEG_W-1:0]      rd_deg;
    logic [Q_W-1:0]        q_rd_data;

    crcgc_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .DEG_W      (DEG_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .data_bit       (data_bit),
        .end_of_message (end_of_message),
        .cmd_push       (q_wr),
        .cmd            (wr_cmd),
        .cmd_rem        (wr_rem),
        .cmd_deg        (wr_deg),
        .cmd_full       (q_full)
    );

    crcgc_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data ({wr_cmd, wr_rem, wr_deg}),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    assign {rd_cmd, rd_rem, rd_deg} = q_rd_data;

    crcgc_back #(
        .MAX_DEGREE (MAX_DEGREE),
        .DEG_W      (DEG_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (q_empty),
        .cmd         (rd_cmd),
        .cmd_rem     (rd_rem),
        .cmd_deg     (rd_deg),
        .cmd_pop     (q_rd),
        .empty       (empty),
        .pop         (pop),
        .result_kind (result_kind),
        .code_bit    (code_bit),
        .error_found (error_found),
        .last_result (last_result)
    );

endmodule

@@ src/crcgc_queue.sv @@
`timescale 1ns / 1ps
// two-entry command queue between the front and back parts
// depends on nothing but its parameter
module crcgc_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              q_full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_empty
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/crcgc_front.sv @@
`timescale 1ns / 1ps
// front part: configuration registers, remainder update and command issue
// depends on crcgc_pkg
module crcgc_front
    import crcgc_pkg::*;
#(
    parameter int MAX_DEGREE = 32,
    parameter int DEG_W      = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [POLY_W-1:0]     cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  data_bit,
    input  logic                  end_of_message,
    output logic                  cmd_push,
    output crcgc_cmd_t            cmd,
    output logic [MAX_DEGREE-1:0] cmd_rem,
    output logic [DEG_W-1:0]      cmd_deg,
    input  logic                  cmd_full
);

    logic [POLY_W-1:0]     poly_low_reg;
    logic [DEGCFG_W-1:0]   poly_deg_reg;
    logic                  check_mode_reg;
    logic [MAX_DEGREE-1:0] rem_reg;
    logic [MAX_DEGREE-1:0] rem_next;

    logic [DEG_W-1:0]      eff_deg;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] topsel;
    logic [MAX_DEGREE-1:0] low_ext;
    logic [MAX_DEGREE-1:0] low_m;
    logic [MAX_DEGREE-1:0] rem_m;
    logic [MAX_DEGREE-1:0] rem_calc;
    logic                  top;
    logic                  fb;
    logic                  accept;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign accept    = push && !cmd_full;

    generate
        if (MAX_DEGREE <= POLY_W)
        begin : g_low_trunc
            assign low_ext = poly_low_reg[MAX_DEGREE-1:0];
        end
        else
        begin : g_low_ext
            assign low_ext = {{(MAX_DEGREE-POLY_W){1'b0}}, poly_low_reg};
        end
    endgenerate

    // clamp degree into 1..MAX_DEGREE
    always_comb
    begin
        priority if (poly_deg_reg == '0)
        begin
            eff_deg = DEG_W'(1);
        end
        else if ({1'b0, poly_deg_reg} > (DEGCFG_W+1)'(MAX_DEGREE))
        begin
            eff_deg = DEG_W'(MAX_DEGREE);
        end
        else
        begin
            eff_deg = DEG_W'(poly_deg_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DEGREE; i++)
        begin
            mask[i]   = (i < int'(eff_deg));
            topsel[i] = (i == int'(eff_deg) - 1);
        end
    end

    always_comb
    begin
        low_m = low_ext & mask;
        rem_m = rem_reg & mask;
        top   = |(rem_m & topsel);
        if (check_mode_reg)
        begin
            // direct division of the received codeword
            fb       = top;
            rem_calc = ((rem_m << 1) | MAX_DEGREE'(data_bit)) & mask;
        end
        else
        begin
            // premultiplied by x^d: feedback is top xor data
            fb       = top ^ data_bit;
            rem_calc = (rem_m << 1) & mask;
        end
        if (fb)
        begin
            rem_calc = rem_calc ^ low_m;
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (accept)
        begin
            rem_next = end_of_message ? '0 : rem_calc;
        end
    end

    // classify: check mode only issues on the final bit
    always_comb
    begin
        cmd_push     = accept && (!check_mode_reg || end_of_message);
        cmd.op       = check_mode_reg ? OP_VERDICT : OP_ECHO;
        cmd.data_bit = check_mode_reg ? 1'b0 : data_bit;
        cmd.err      = check_mode_reg && (|rem_calc);
        cmd.tail     = !check_mode_reg && end_of_message;
        cmd_rem      = rem_calc;
        cmd_deg      = eff_deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_low_reg   <= POLY_LOW_RST;
            poly_deg_reg   <= POLY_DEG_RST;
            check_mode_reg <= 1'b0;
            rem_reg        <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_POLY_LOW:   poly_low_reg   <= cfg_data;
                    CFG_POLY_DEG:   poly_deg_reg   <= cfg_data[DEGCFG_W-1:0];
                    CFG_CHECK_MODE: check_mode_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

@@ src/crcgc_back.sv @@
`timescale 1ns / 1ps
// back part: turns commands into result items, shifting out crc tails
// depends on crcgc_pkg
module crcgc_back
    import crcgc_pkg::*;
#(
    parameter int MAX_DEGREE = 32,
    parameter int DEG_W      = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_empty,
    input  crcgc_cmd_t            cmd,
    input  logic [MAX_DEGREE-1:0] cmd_rem,
    input  logic [DEG_W-1:0]      cmd_deg,
    output logic                  cmd_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic                  result_kind,
    output logic                  code_bit,
    output logic                  error_found,
    output logic                  last_result
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_kind_reg;
    logic                  out_kind_next;
    logic                  out_bit_reg;
    logic                  out_bit_next;
    logic                  out_err_reg;
    logic                  out_err_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic [DEG_W-1:0]      tail_cnt_reg;
    logic [DEG_W-1:0]      tail_cnt_next;
    logic [MAX_DEGREE-1:0] tail_rem_reg;
    logic [MAX_DEGREE-1:0] tail_rem_next;

    logic                  advance;
    logic                  tail_busy;
    logic [MAX_DEGREE-1:0] tail_sel;

    assign empty       = !out_valid_reg;
    assign result_kind = out_kind_reg;
    assign code_bit    = out_bit_reg;
    assign error_found = out_err_reg;
    assign last_result = out_last_reg;

    assign advance   = !out_valid_reg || pop;
    assign tail_busy = (tail_cnt_reg != '0);
    assign cmd_pop   = advance && !tail_busy && !cmd_empty;

    always_comb
    begin
        for (int i = 0; i < MAX_DEGREE; i++)
        begin
            tail_sel[i] = (i + 1 == int'(tail_cnt_reg));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_bit_next   = out_bit_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        tail_cnt_next  = tail_cnt_reg;
        tail_rem_next  = tail_rem_reg;
        if (advance)
        begin
            priority if (tail_busy)
            begin
                // remainder bits, highest first
                out_valid_next = 1'b1;
                out_kind_next  = OP_ECHO;
                out_bit_next   = |(tail_rem_reg & tail_sel);
                out_err_next   = 1'b0;
                out_last_next  = (tail_cnt_reg == DEG_W'(1));
                tail_cnt_next  = tail_cnt_reg - DEG_W'(1);
            end
            else if (!cmd_empty)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = cmd.op;
                out_bit_next   = cmd.data_bit;
                out_err_next   = cmd.err;
                out_last_next  = (cmd.op == OP_VERDICT);
                if (cmd.tail)
                begin
                    tail_cnt_next = cmd_deg;
                    tail_rem_next = cmd_rem;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_bit_reg  <= out_bit_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
        tail_rem_reg <= tail_rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tail_cnt_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tail_cnt_reg  <= tail_cnt_next;
        end
    end

endmodule

@@ src/crcgc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for crc_generate_and_check, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module crcgc_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic empty,
    input  logic pop,
    input  logic result_kind,
    input  logic code_bit,
    input  logic error_found,
    input  logic last_result
);

    // verdicts carry no code bit and always close the message
    `ASSERT_CLKD(a_verdict_no_bit, (!empty && result_kind) |-> !code_bit, "verdict with code bit")
    `ASSERT_CLKD(a_verdict_last, (!empty && result_kind) |-> last_result, "verdict not last")
    // codeword bits never report an error
    `ASSERT_CLKD(a_code_no_err, (!empty && !result_kind) |-> !error_found, "code bit with error")
    // a waiting result stays until its transfer
    `ASSERT_CLKD(a_hold_valid, (!empty && !pop) |=> !empty, "result dropped")
    `ASSERT_CLKD(a_hold_data, (!empty && !pop) |=> ($stable(result_kind) && $stable(code_bit) && $stable(error_found) && $stable(last_result)), "result changed while stalled")

endmodule

bind crc_generate_and_check crcgc_checker u_crcgc_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench for crc_generate_and_check: a directed table, then random messages
// and codewords, every result checked against a bit-serial crc predictor
// depends on crcgc_pkg and the crc_generate_and_check rtl
module testbench;
    import crcgc_pkg::*;

    localparam int NUM_DIRECTED   = 34;
    localparam int ITEM_TARGET    = 270;
    localparam int CALM_AFTER     = 230;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_DEG        = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam logic [POLY_W-1:0]    MODE_GENERATE = 32'd0;
    localparam logic [POLY_W-1:0]    MODE_CHECK    = 32'd1;

    typedef struct packed {
        logic kind;
        logic cbit;
        logic err;
        logic last_res;
    } crc_res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [POLY_W-1:0]      wdata;
        logic                   dbit;
        logic                   eom;
        logic                   typed;
        crc_res_t               want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POLY_W-1:0]    cfg_data;
    logic                 push;
    logic                 full;
    logic                 data_bit;
    logic                 end_of_message;
    logic                 empty;
    logic                 pop;
    logic                 result_kind;
    logic                 code_bit;
    logic                 error_found;
    logic                 last_result;

    // predictor copy of the block's registers and remainder
    logic [POLY_W-1:0]    poly_low;
    logic [DEGCFG_W-1:0]  poly_deg;
    logic                 check_on;
    logic [63:0]          crc_rem;

    crc_res_t             pending_results[$];
    crc_res_t             oldest;
    plan_row_t            plan[NUM_DIRECTED];
    int                   items_sent;
    int                   cfg_writes;
    int                   results_seen;
    int                   mismatches;
    int                   stuck_cycles;
    logic                 calm;

    crc_generate_and_check dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .data_bit       (data_bit),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .result_kind    (result_kind),
        .code_bit       (code_bit),
        .error_found    (error_found),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic plan_row_t item_row(logic dbit, logic eom, logic typed = 1'b0,
                                           crc_res_t want = '0);
        return '{ROW_ITEM, CFG_POLY_LOW, '0, dbit, eom, typed, want};
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [POLY_W-1:0] wdata);
        return '{ROW_CFG, idx, wdata, 1'b0, 1'b0, 1'b0, crc_res_t'(0)};
    endfunction

    // degree 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int eff_degree();
        int d;
        d = int'(poly_deg);
        if (d == 0)
            d = 1;
        if (d > MAX_DEG)
            d = MAX_DEG;
        return d;
    endfunction

    function automatic void predict_crc_outputs(logic dbit, logic eom);
        int          d;
        logic [63:0] mask;
        logic [63:0] low;
        logic [63:0] r;
        logic        top;
        d    = eff_degree();
        mask = (64'd1 << d) - 64'd1;
        low  = {32'd0, poly_low} & mask;
        r    = crc_rem & mask;
        top  = r[d-1];
        if (check_on)
        begin
            r = ((r << 1) | {63'd0, dbit}) & mask;
            if (top)
                r ^= low;
            crc_rem = r;
            if (eom)
            begin
                pending_results.push_back('{OP_VERDICT, 1'b0, r != 64'd0, 1'b1});
                crc_rem = '0;
            end
        end
        else
        begin
            // feedback of top xor data premultiplies the message by x^d
            r = (r << 1) & mask;
            if (top ^ dbit)
                r ^= low;
            crc_rem = r;
            pending_results.push_back('{OP_ECHO, dbit, 1'b0, 1'b0});
            if (eom)
            begin
                for (int i = d; i > 0; i--)
                    pending_results.push_back('{OP_ECHO, r[i-1], 1'b0, i == 1});
                crc_rem = '0;
            end
        end
    endfunction

    task automatic report(string what);
        mismatches++;
        $display("%0t: %s", $time, what);
    endtask

    task automatic check_field(string name, logic got, logic want);
        if (got !== want)
            report($sformatf("result %0d: %s is %b, expected %b",
                             results_seen, name, got, want));
    endtask

    task automatic send_item(logic dbit, logic eom);
        cfg_valid <= 1'b0;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        push           <= 1'b1;
        data_bit       <= dbit;
        end_of_message <= eom;
        do @(posedge clk); while (full);
        predict_crc_outputs(dbit, eom);
        items_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POLY_W-1:0] wdata);
        push      <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= wdata;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_POLY_LOW:   poly_low = wdata;
            CFG_POLY_DEG:   poly_deg = wdata[DEGCFG_W-1:0];
            CFG_CHECK_MODE: check_on = wdata[0];
            default:        ;
        endcase
        cfg_writes++;
    endtask

    // sender holds off until every expected result is out, then lets the pipe settle
    task automatic drain();
        push      <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_settings();
        logic [POLY_W-1:0] w;
        int                pick;
        drain();
        pick = $urandom_range(0, 9);
        w    = $urandom;
        case (pick)
            0:       w[5:0] = 6'd1;
            1:       w[5:0] = 6'd32;
            2:       w[5:0] = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
            default: w[5:0] = 6'($urandom_range(2, 16));
        endcase
        write_reg(CFG_POLY_DEG, w);
        pick = $urandom_range(0, 9);
        w    = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
        write_reg(CFG_POLY_LOW, w);
        write_reg(CFG_CHECK_MODE, $urandom);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, $urandom);
    endtask

    // check mode mostly gets valid codewords, some with one flipped bit, some noise
    task automatic send_message();
        logic        bits[$];
        int          len;
        int          flavor;
        int          d;
        int          flip;
        logic [63:0] mask;
        logic [63:0] low;
        logic [63:0] r;
        logic        top;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        for (int i = 0; i < len; i++)
            bits.push_back(logic'($urandom_range(0, 1)));
        flavor = $urandom_range(0, 9);
        if (check_on && flavor < 8)
        begin
            d    = eff_degree();
            mask = (64'd1 << d) - 64'd1;
            low  = {32'd0, poly_low} & mask;
            r    = '0;
            foreach (bits[i])
            begin
                top = r[d-1];
                r   = (r << 1) & mask;
                if (top ^ bits[i])
                    r ^= low;
            end
            for (int i = d; i > 0; i--)
                bits.push_back(r[i-1]);
            if (flavor >= 6)
            begin
                flip       = $urandom_range(0, bits.size() - 1);
                bits[flip] = ~bits[flip];
            end
        end
        foreach (bits[i])
            send_item(bits[i], i == bits.size() - 1);
    endtask

    // receiver: pop stalls in random bursts until the last part of the run
    initial
    begin
        pop <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
                report("result transfer with nothing expected");
            else
            begin
                oldest = pending_results.pop_front();
                check_field("result_kind", result_kind, oldest.kind);
                check_field("code_bit", code_bit, oldest.cbit);
                check_field("error_found", error_found, oldest.err);
                check_field("last_result", last_result, oldest.last_res);
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic was_item;
        int   msgs;
        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        push           <= 1'b0;
        data_bit       <= 1'b0;
        end_of_message <= 1'b0;
        poly_low       = POLY_LOW_RST;
        poly_deg       = POLY_DEG_RST;
        check_on       = 1'b0;
        crc_rem        = '0;
        items_sent     = 0;
        cfg_writes     = 0;
        results_seen   = 0;
        mismatches     = 0;
        stuck_cycles   = 0;
        calm           = 1'b0;
        was_item       = 1'b0;
        msgs           = 0;

        plan = '{
            // reset settings: degree 8, x^8+x^2+x+1, generate
            item_row(1'b1, 1'b0, 1'b1, '{OP_ECHO, 1'b1, 1'b0, 1'b0}),
            item_row(1'b0, 1'b1),
            cfg_row(CFG_CHECK_MODE, MODE_CHECK),
            item_row(1'b0, 1'b1, 1'b1, '{OP_VERDICT, 1'b0, 1'b0, 1'b1}),
            item_row(1'b1, 1'b1, 1'b1, '{OP_VERDICT, 1'b0, 1'b1, 1'b1}),
            // degree zero acts as degree one
            cfg_row(CFG_POLY_DEG, 32'd0),
            cfg_row(CFG_POLY_LOW, 32'h0000_0000),
            item_row(1'b1, 1'b0),
            item_row(1'b0, 1'b1),
            // oversized degree acts as the maximum
            cfg_row(CFG_POLY_DEG, 32'd63),
            cfg_row(CFG_POLY_LOW, 32'hFFFF_FFFF),
            item_row(1'b1, 1'b1, 1'b1, '{OP_VERDICT, 1'b0, 1'b1, 1'b1}),
            cfg_row(CFG_CHECK_MODE, MODE_GENERATE),
            item_row(1'b1, 1'b1),
            // degree one, poly bits above the degree ignored
            cfg_row(CFG_POLY_DEG, 32'd1),
            item_row(1'b1, 1'b0),
            item_row(1'b1, 1'b1),
            cfg_row(CFG_SPARE, 32'hFFFF_FFFF),
            item_row(1'b0, 1'b1),
            // settings change in the middle of a message, mode switch keeps remainder
            cfg_row(CFG_POLY_DEG, 32'd16),
            cfg_row(CFG_POLY_LOW, 32'h0000_1021),
            item_row(1'b1, 1'b0),
            item_row(1'b0, 1'b0),
            item_row(1'b1, 1'b0),
            cfg_row(CFG_POLY_DEG, 32'd5),
            cfg_row(CFG_POLY_LOW, 32'h0000_0005),
            cfg_row(CFG_CHECK_MODE, MODE_CHECK),
            item_row(1'b1, 1'b0),
            item_row(1'b0, 1'b1),
            cfg_row(CFG_POLY_DEG, 32'd32),
            cfg_row(CFG_POLY_LOW, 32'h04C1_1DB7),
            cfg_row(CFG_CHECK_MODE, MODE_GENERATE),
            item_row(1'b1, 1'b0),
            item_row(1'b1, 1'b1)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_CFG)
            begin
                if (was_item)
                    drain();
                write_reg(plan[n].idx, plan[n].wdata);
                was_item = 1'b0;
            end
            else
            begin
                send_item(plan[n].dbit, plan[n].eom);
                // rows with a hand-written expectation cause exactly one result
                if (plan[n].typed)
                    pending_results[pending_results.size() - 1] = plan[n].want;
                was_item = 1'b1;
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            random_settings();
            msgs = $urandom_range(2, 5);
            for (int m = 0; m < msgs && items_sent < ITEM_TARGET; m++)
                send_message();
        end

        drain();
        $display("%0d input bits and %0d register writes, %0d results checked",
                 items_sent, cfg_writes, results_seen);
        $display("covered generate and check modes, degrees 1 to 32 and clamped settings");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
